### rtl/triangle_normal_area_macros.svh
// Assertion helpers for the checker file tna_checker.sv.
`ifndef TRIANGLE_NORMAL_AREA_MACROS_SVH
`define TRIANGLE_NORMAL_AREA_MACROS_SVH

// Implication in the same cycle, masked while reset is low.
`define TNA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, not masked by reset.
`define TNA_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tna_pkg.sv
package tna_pkg;

  localparam int COORD_W = 16;
  // magnitude of one cross product component
  localparam int MW = 2 * COORD_W + 1;
  // squared cross length
  localparam int SW = 2 * MW + 2;
  // integer square root bits
  localparam int RW = SW / 2;
  // quotient bits of one normal component (holds 2^14)
  localparam int QW = 15;
  localparam int DW = SW + 2 * QW + 1;
  localparam int BW = SW + QW;
  localparam int NSTG = RW;
  localparam int FRONT_STAGES = 5;
  localparam int LATENCY = FRONT_STAGES + NSTG + 1;
  localparam int AREA_W = 33;
  localparam int NORM_W = 16;
  localparam int CMP_W = (RW > AREA_W + 1) ? RW : AREA_W + 1;
  localparam int FRAC_SHIFT = 28;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tna_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [AREA_W-1:0]        area;
    logic                     degenerate;
  } tna_out_t;

  // front end to root stages
  typedef struct packed {
    logic [SW-1:0]          s;
    logic [2:0][2*MW-1:0]   sq;
    logic [2:0]             neg;
  } tna_mid_t;

  // one iteration stage of square root and the three normal quotients
  typedef struct packed {
    logic [SW-1:0]          s;
    logic [RW-1:0]          rr;
    logic [SW-1:0]          dr;
    logic [2:0][QW-1:0]     q;
    logic [2:0][DW-1:0]     dn;
    logic [2:0][BW-1:0]     bn;
    logic [2:0]             neg;
  } tna_it_t;

endpackage

### rtl/tna_front.sv
module tna_front
  import tna_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  tna_in_t  in_data,
  output logic     out_vld,
  output tna_mid_t out_mid
);

  logic [FRONT_STAGES-1:0] vld_r;

  logic signed [COORD_W:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [2*COORD_W+1:0] p_r [6];
  logic [MW-1:0] mag_r [3];
  logic [2:0] neg3_r, neg4_r;
  logic [2*MW-1:0] sq_r [3];
  tna_mid_t mid_r;

  logic signed [2*COORD_W+1:0] n_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], in_vld};
    end
  end

  // edge vectors
  always_ff @(posedge clk) begin
    ux_r <= (COORD_W+1)'(in_data.b_x) - (COORD_W+1)'(in_data.a_x);
    uy_r <= (COORD_W+1)'(in_data.b_y) - (COORD_W+1)'(in_data.a_y);
    uz_r <= (COORD_W+1)'(in_data.b_z) - (COORD_W+1)'(in_data.a_z);
    vx_r <= (COORD_W+1)'(in_data.c_x) - (COORD_W+1)'(in_data.a_x);
    vy_r <= (COORD_W+1)'(in_data.c_y) - (COORD_W+1)'(in_data.a_y);
    vz_r <= (COORD_W+1)'(in_data.c_z) - (COORD_W+1)'(in_data.a_z);
  end

  // cross product partial products
  always_ff @(posedge clk) begin
    p_r[0] <= uy_r * vz_r;
    p_r[1] <= uz_r * vy_r;
    p_r[2] <= uz_r * vx_r;
    p_r[3] <= ux_r * vz_r;
    p_r[4] <= ux_r * vy_r;
    p_r[5] <= uy_r * vx_r;
  end

  always_comb begin
    n_nxt[0] = p_r[0] - p_r[1];
    n_nxt[1] = p_r[2] - p_r[3];
    n_nxt[2] = p_r[4] - p_r[5];
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      neg3_r[j] <= n_nxt[j][2*COORD_W+1];
      mag_r[j]  <= n_nxt[j][2*COORD_W+1] ? MW'(-n_nxt[j]) : MW'(n_nxt[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sq_r[j] <= mag_r[j] * mag_r[j];
    end
    neg4_r <= neg3_r;
  end

  always_ff @(posedge clk) begin
    mid_r.s   <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    mid_r.sq  <= {sq_r[2], sq_r[1], sq_r[0]};
    mid_r.neg <= neg4_r;
  end

  assign out_vld = vld_r[FRONT_STAGES-1];
  assign out_mid = mid_r;

endmodule

### rtl/tna_root.sv
module tna_root
  import tna_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  tna_mid_t in_mid,
  output logic     out_vld,
  output tna_it_t  out_it
);

  logic [NSTG-1:0] vld_r;
  tna_it_t stg_in  [NSTG];
  tna_it_t stg_nxt [NSTG];
  tna_it_t stg_r   [NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_vld};
    end
  end

  always_comb begin
    stg_in[0].s   = in_mid.s;
    stg_in[0].rr  = '0;
    stg_in[0].dr  = in_mid.s;
    stg_in[0].q   = '0;
    stg_in[0].bn  = '0;
    stg_in[0].neg = in_mid.neg;
    for (int j = 0; j < 3; j++) begin
      stg_in[0].dn[j] = DW'(in_mid.sq[j]) << FRAC_SHIFT;
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int B  = RW - 1 - k;
    localparam int NB = (k < QW) ? QW - 1 - k : 0;

    if (k > 0) begin : g_link
      assign stg_in[k] = stg_r[k-1];
    end

    logic [SW:0]   amt;
    logic [DW-1:0] namt [3];

    always_comb begin
      stg_nxt[k] = stg_in[k];
      // square root: try bit B
      amt = ((SW+1)'(stg_in[k].rr) << (B + 1)) | ((SW+1)'(1) << (2 * B));
      if (amt <= (SW+1)'(stg_in[k].dr)) begin
        stg_nxt[k].dr = stg_in[k].dr - SW'(amt);
        stg_nxt[k].rr = stg_in[k].rr | (RW'(1) << B);
      end
      // q^2*S is tracked as the remainder dn; bn holds q*S
      for (int j = 0; j < 3; j++) begin
        namt[j] = '0;
        if (k < QW) begin
          namt[j] = (DW'(stg_in[k].bn[j]) << (NB + 1)) + (DW'(stg_in[k].s) << (2 * NB));
          if (namt[j] <= stg_in[k].dn[j]) begin
            stg_nxt[k].dn[j] = stg_in[k].dn[j] - namt[j];
            stg_nxt[k].bn[j] = stg_in[k].bn[j] + (BW'(stg_in[k].s) << NB);
            stg_nxt[k].q[j]  = stg_in[k].q[j] | (QW'(1) << NB);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= stg_nxt[k];
    end
  end

  assign out_vld = vld_r[NSTG-1];
  assign out_it  = stg_r[NSTG-1];

endmodule

### rtl/triangle_normal_area.sv
// Channel  | Ports                       | Handshake
// ---------+-----------------------------+-------------------------------------
// input    | start, busy, in_data        | beat taken when start && !busy
// result   | out_valid, out_data         | one-cycle strobe, no backpressure
//
// One triangle enters every cycle; busy stays low. Each result appears
// once its start beat has passed through 5 front stages (edges, products,
// cross, squares, sum), 34 square root / normal stages (one root bit each),
// and one output register. The square root bit count sets the depth.
// rst_n is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline always advances.
module triangle_normal_area
  import tna_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tna_in_t  in_data,
  output logic     out_valid,
  output tna_out_t out_data
);

  logic     mid_vld;
  tna_mid_t mid;
  logic     it_vld;
  tna_it_t  it;

  logic     out_valid_r;
  tna_out_t out_data_r;
  tna_out_t out_nxt;

  logic [RW-2:0]       half;
  logic [NORM_W-1:0]   nrm [3];
  logic                deg;

  // nothing ever holds the pipeline back
  assign busy = 1'b0;

  tna_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_data (in_data),
    .out_vld (mid_vld),
    .out_mid (mid)
  );

  tna_root u_root (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mid_vld),
    .in_mid  (mid),
    .out_vld (it_vld),
    .out_it  (it)
  );

  // final formatting: sign the quotients, halve and clamp the root, zero degenerate results
  always_comb begin
    deg  = (it.s == '0);
    half = it.rr[RW-1:1];
    for (int j = 0; j < 3; j++) begin
      if (deg) begin
        nrm[j] = '0;
      end else if (it.neg[j]) begin
        nrm[j] = NORM_W'(-NORM_W'(it.q[j]));
      end else begin
        nrm[j] = NORM_W'(it.q[j]);
      end
    end
    out_nxt.normal_x   = nrm[0];
    out_nxt.normal_y   = nrm[1];
    out_nxt.normal_z   = nrm[2];
    out_nxt.degenerate = deg;
    if (deg) begin
      out_nxt.area = '0;
    end else if (CMP_W'(half) > CMP_W'({AREA_W{1'b1}})) begin
      out_nxt.area = '1;
    end else begin
      out_nxt.area = AREA_W'(CMP_W'(half));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= it_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/tna_checker.sv
`include "triangle_normal_area_macros.svh"

module tna_checker
  import tna_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input tna_in_t  in_data,
  input logic     out_valid,
  input tna_out_t out_data
);

  `TNA_ASSERT_NEXT(a_rst_clears, clk, !rst_n, !out_valid, "result strobe right after reset")

  `TNA_ASSERT_IMP(a_latency, clk, rst_n, out_valid, $past(start && !busy, LATENCY), "result without a start beat")

  `TNA_ASSERT_IMP(a_degen, clk, rst_n, out_valid && out_data.degenerate, (out_data.area == '0) && (out_data.normal_x == '0) && (out_data.normal_y == '0) && (out_data.normal_z == '0), "degenerate result not zero")

  `TNA_ASSERT_IMP(a_unit, clk, rst_n, out_valid, (out_data.normal_x <= 16'sd16384) && (out_data.normal_x >= -16'sd16384) && (out_data.normal_y <= 16'sd16384) && (out_data.normal_y >= -16'sd16384) && (out_data.normal_z <= 16'sd16384) && (out_data.normal_z >= -16'sd16384), "normal component out of range")

endmodule

bind triangle_normal_area tna_checker u_tna_checker (.*);
